@@ hdl/fkm_pkg.sv @@
// Package for the frequent k-mer search core: payload structs, state codes
// and fixed field widths. No dependencies.
package fkm_pkg;

   localparam int TEXT_MAX_DEF   = 1024;
   localparam int K_MAX_DEF      = 6;
   localparam int MAX_REPORT_DEF = 64;

   localparam int CODE_W  = 12;
   localparam int COUNT_W = 11;
   localparam int CFG_W   = 3;
   localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

   typedef enum logic [0:0] {
      REG_KMER_LENGTH    = 1'b0,
      REG_MAX_MISMATCHES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] nucleotide;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]  pattern_code;
      logic [COUNT_W-1:0] occurrence_count;
      logic               found;
      logic               truncated;
      logic               last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_WIN_RD, ST_WIN_SH, ST_SCAN, ST_SCAN_TAIL,
      ST_RPT_RD, ST_RPT_CHK, ST_FLUSH, ST_EMPTY
   } state_type;

endpackage

@@ hdl/frequent_kmer_with_mismatches_core.sv @@
// Frequent k-mer search with mismatches: text memory, count memory, sequencer.
// Depends on fkm_pkg.
// Loading takes one symbol per cycle while idle and stalls during a run; after the
// last symbol a run clears the count memory, counts every window against every
// pattern within d mismatches, then reads and checks each count in turn to report
// the tied most-frequent patterns, or one empty result for a text shorter than k.
// Reset (synchronous, active high) empties the text and loads k=3, d=1.
module frequent_kmer_with_mismatches_core #(
   parameter int TEXT_MAX   = fkm_pkg::TEXT_MAX_DEF,
   parameter int K_MAX      = fkm_pkg::K_MAX_DEF,
   parameter int MAX_REPORT = fkm_pkg::MAX_REPORT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fkm_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output fkm_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  fkm_pkg::csr_index_type          csr_index,
   input  logic [fkm_pkg::CFG_W-1:0]       csr_wdata
);
   import fkm_pkg::*;

   localparam int TW     = $clog2(TEXT_MAX);
   localparam int ADDR_W = 2 * K_MAX;
   localparam int NPAT   = 1 << ADDR_W;
   localparam int NUM_W  = $clog2(MAX_REPORT + 1);
   localparam int MM_W   = $clog2(K_MAX + 1);

   logic [CFG_W-1:0] kreg_ff, dreg_ff;
   state_type state_ff, state_in;
   logic [TW:0]       len_ff, len_in;
   logic [TW-1:0]     idx_ff, idx_in;
   logic [ADDR_W-1:0] win_ff, win_in, p_ff, p_in, addr_d_ff, pend_ff, pend_in;
   logic              rd_pend_ff, rd_pend_in, have_pend_ff, have_pend_in;
   logic [COUNT_W-1:0] best_ff, best_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [1:0]        txt_mem [TEXT_MAX];
   logic [1:0]        txt_rd_ff;
   logic              txt_we, txt_re;
   logic [COUNT_W-1:0] cnt_mem [NPAT];
   logic [COUNT_W-1:0] cnt_rd_ff, cnt_wd, cnt_new;
   logic              cnt_we, cnt_re;
   logic [ADDR_W-1:0] cnt_wa, cnt_ra;

   logic [CFG_W-1:0]  keff;
   logic [ADDR_W-1:0] mask;
   logic              out_free;
   logic [MM_W-1:0]   mm;

   function automatic logic [MM_W-1:0] mismatch_count(input logic [ADDR_W-1:0] x);
      logic [MM_W-1:0] n;
      n = '0;
      for (int j = 0; j < K_MAX; j++)
         if (x[2*j +: 2] != 2'd0) n = n + MM_W'(1);
      return n;
   endfunction

   always_comb begin
      if (kreg_ff == '0) keff = CFG_W'(1);
      else if (32'(kreg_ff) > K_MAX) keff = CFG_W'(K_MAX);
      else keff = kreg_ff;
      mask = ADDR_W'((64'(1) << (2 * keff)) - 64'(1));
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign mm      = mismatch_count(addr_d_ff ^ win_ff);
   assign cnt_new = ((32'(mm) <= 32'(dreg_ff)) && (cnt_rd_ff != COUNT_SAT)) ?
                    cnt_rd_ff + COUNT_W'(1) : cnt_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kreg_ff <= CFG_W'(3);
         dreg_ff <= CFG_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_KMER_LENGTH:    kreg_ff <= csr_wdata;
            REG_MAX_MISMATCHES: dreg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (txt_we) txt_mem[len_ff[TW-1:0]] <= req_data.nucleotide;
      if (txt_re) txt_rd_ff <= txt_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      if (cnt_re) cnt_rd_ff <= cnt_mem[cnt_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         best_ff      <= '0;
         num_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rd_pend_ff   <= rd_pend_in;
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         best_ff      <= best_in;
         num_ff       <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      win_ff    <= win_in;
      p_ff      <= p_in;
      addr_d_ff <= p_ff;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      win_in       = win_ff;
      p_in         = p_ff;
      pend_in      = pend_ff;
      rd_pend_in   = 1'b0;
      have_pend_in = have_pend_ff;
      best_in      = best_ff;
      num_in       = num_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      txt_we = 1'b0;
      txt_re = 1'b0;
      cnt_we = 1'b0;
      cnt_re = 1'b0;
      cnt_wa = p_ff;
      cnt_ra = p_ff;
      cnt_wd = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (32'(len_ff) < TEXT_MAX) begin
                  txt_we = 1'b1;
                  len_in = len_ff + (TW+1)'(1);
               end
               if (req_data.is_last) begin
                  p_in     = '0;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            cnt_we = 1'b1;
            if (p_ff == mask) begin
               best_in = '0;
               idx_in  = '0;
               win_in  = '0;
               state_in = (len_ff < (TW+1)'(keff)) ? ST_EMPTY : ST_WIN_RD;
            end else begin
               p_in = p_ff + ADDR_W'(1);
            end
         end
         ST_WIN_RD: begin
            txt_re   = 1'b1;
            state_in = ST_WIN_SH;
         end
         ST_WIN_SH: begin
            win_in = ((win_ff << 2) | ADDR_W'(txt_rd_ff)) & mask;
            if (32'(idx_ff) >= 32'(keff) - 1) begin
               p_in     = '0;
               state_in = ST_SCAN;
            end else begin
               idx_in   = idx_ff + TW'(1);
               state_in = ST_WIN_RD;
            end
         end
         ST_SCAN, ST_SCAN_TAIL: begin
            // read next pattern while writing back the previous one
            if (rd_pend_ff) begin
               cnt_we = 1'b1;
               cnt_wa = addr_d_ff;
               cnt_wd = cnt_new;
               if (cnt_new > best_ff) best_in = cnt_new;
            end
            if (state_ff == ST_SCAN) begin
               cnt_re     = 1'b1;
               rd_pend_in = 1'b1;
               if (p_ff == mask) state_in = ST_SCAN_TAIL;
               else p_in = p_ff + ADDR_W'(1);
            end else if ((TW+1)'(idx_ff) + (TW+1)'(1) == len_ff) begin
               p_in         = '0;
               have_pend_in = 1'b0;
               num_in       = '0;
               state_in     = ST_RPT_RD;
            end else begin
               idx_in   = idx_ff + TW'(1);
               state_in = ST_WIN_RD;
            end
         end
         ST_RPT_RD: begin
            cnt_re   = 1'b1;
            state_in = ST_RPT_CHK;
         end
         ST_RPT_CHK: begin
            if (cnt_rd_ff == best_ff && have_pend_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{CODE_W'(pend_ff), best_ff, 1'b1, 1'b0, 1'b0};
                  if (num_ff == NUM_W'(MAX_REPORT)) begin
                     rsp_in.truncated   = 1'b1;
                     rsp_in.last_result = 1'b1;
                     len_in   = '0;
                     state_in = ST_IDLE;
                  end else begin
                     pend_in = p_ff;
                     num_in  = num_ff + NUM_W'(1);
                     if (p_ff == mask) state_in = ST_FLUSH;
                     else begin
                        p_in = p_ff + ADDR_W'(1);
                        state_in = ST_RPT_RD;
                     end
                  end
               end
            end else begin
               if (cnt_rd_ff == best_ff) begin
                  pend_in      = p_ff;
                  have_pend_in = 1'b1;
                  num_in       = NUM_W'(1);
               end
               if (p_ff == mask) state_in = ST_FLUSH;
               else begin
                  p_in = p_ff + ADDR_W'(1);
                  state_in = ST_RPT_RD;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in   = '{CODE_W'(pend_ff), best_ff, 1'b1, 1'b0, 1'b1};
               len_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in   = '{CODE_W'(0), COUNT_W'(0), 1'b0, 1'b0, 1'b1};
               len_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.last_result)
      else $error("empty result not marked last");
   a_trunc_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.truncated |-> rsp_data.last_result)
      else $error("truncation flagged before last result");
   a_rmw_distinct: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && rd_pend_ff |-> addr_d_ff != p_ff)
      else $error("count read and write hit the same entry");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for frequent_kmer_with_mismatches_core: streams DNA texts,
// predicts the tied most-frequent k-mers and checks every result. Uses fkm_pkg.
module tb;
   import fkm_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = REG_KMER_LENGTH;
   logic [2:0]    csr_wdata = '0;

   frequent_kmer_with_mismatches_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   localparam int DRAIN_CYCLES = 2 * 4096 + 200;

   req_type    symbol_queue[$];
   rsp_type    expected_hits[$];
   logic [1:0] text_mem[1024];
   int         text_len = 0;
   logic [2:0] kmer_len_cfg = 3'd3;
   logic [2:0] max_mm_cfg = 3'd1;
   int         idle_pct = 0;
   int         stall_pct = 0;
   int         errors = 0;
   int         hits_checked = 0;
   int         texts_sent = 0;
   logic       req_taken = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   // Work out every result that the closing symbol of a text causes.
   function automatic void predict_frequent_kmers();
      int      k, npat, w, best, n, mm;
      int      cnt[4096];
      rsp_type hit;
      k = (kmer_len_cfg == 0) ? 1 : (kmer_len_cfg > 6) ? 6 : kmer_len_cfg;
      npat = 1 << (2 * k);
      w = 0;
      best = 0;
      n = 0;
      foreach (cnt[p]) cnt[p] = 0;
      if (text_len >= k) begin
         for (int i = 0; i < text_len; i++) begin
            w = ((w << 2) | text_mem[i]) & (npat - 1);
            if (i + 1 >= k) begin
               for (int p = 0; p < npat; p++) begin
                  mm = 0;
                  for (int j = 0; j < k; j++)
                     if ((((p ^ w) >> (2 * j)) & 3) != 0) mm++;
                  if (mm <= max_mm_cfg && cnt[p] < 2047) cnt[p]++;
               end
            end
         end
         for (int p = 0; p < npat; p++)
            if (cnt[p] > best) best = cnt[p];
      end
      if (best == 0) begin
         hit = '0;
         hit.last_result = 1'b1;
         expected_hits = {expected_hits, hit};
      end else begin
         for (int p = 0; p < npat; p++) begin
            if (cnt[p] == best) begin
               if (n == 64) begin
                  expected_hits[expected_hits.size() - 1].truncated = 1'b1;
                  break;
               end
               hit = '0;
               hit.pattern_code = p[11:0];
               hit.occurrence_count = best[10:0];
               hit.found = 1'b1;
               expected_hits = {expected_hits, hit};
               n++;
            end
         end
         expected_hits[expected_hits.size() - 1].last_result = 1'b1;
      end
   endfunction

   // Driver: present the next symbol or idle.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (symbol_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_data <= symbol_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Monitor: record accepted symbols and check results.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (text_len < 1024) begin
               text_mem[text_len] = req_data.nucleotide;
               text_len = text_len + 1;
            end
            if (req_data.is_last) begin
               predict_frequent_kmers();
               text_len = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
               errors++;
            end else begin
               if (rsp_data.pattern_code !== expected_hits[0].pattern_code ||
                   rsp_data.occurrence_count !== expected_hits[0].occurrence_count ||
                   rsp_data.found !== expected_hits[0].found ||
                   rsp_data.truncated !== expected_hits[0].truncated ||
                   rsp_data.last_result !== expected_hits[0].last_result) begin
                  $display("%0t: result mismatch, expected %p, actual %p",
                           $time, expected_hits[0], rsp_data);
                  errors++;
               end
               void'(expected_hits.pop_front());
               hits_checked++;
            end
         end
      end
   end

   task automatic push_text(int len);
      req_type sym;
      for (int i = 0; i < len; i++) begin
         sym.nucleotide = 2'($urandom_range(0, 3));
         sym.is_last = (i == len - 1);
         symbol_queue = {symbol_queue, sym};
      end
      texts_sent++;
   endtask

   task automatic push_fixed(logic [1:0] seq[], int len);
      req_type sym;
      for (int i = 0; i < len; i++) begin
         sym.nucleotide = seq[i];
         sym.is_last = (i == len - 1);
         symbol_queue = {symbol_queue, sym};
      end
      texts_sent++;
   endtask

   // Wait until the block has gone quiet.
   task automatic drain();
      while (symbol_queue.size() > 0 || req_valid || expected_hits.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [2:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_KMER_LENGTH) kmer_len_cfg = value;
      else max_mm_cfg = value;
   endtask

   task automatic set_mode(int mode);
      case (mode % 4)
         0: begin idle_pct = 0; stall_pct = 0; end
         1: begin idle_pct = 50; stall_pct = 0; end
         2: begin idle_pct = 0; stall_pct = 50; end
         default: begin idle_pct = 26; stall_pct = 26; end
      endcase
   endtask

   initial begin
      logic [1:0] seq[];
      int         ks[10] = '{1, 2, 3, 3, 2, 5, 4, 6, 3, 1};
      int         ds[10] = '{0, 1, 0, 2, 0, 1, 1, 2, 1, 1};
      int         sent, maxlen, len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset setting, short text, single symbol, mixed text.
      seq = '{2'd0, 2'd3};
      push_fixed(seq, 2);
      seq = '{2'd3};
      push_fixed(seq, 1);
      seq = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd1, 2'd0, 2'd0, 2'd1};
      push_fixed(seq, 10);
      drain();
      // Distance at or above k: everything ties, report truncates.
      write_reg(REG_KMER_LENGTH, 3'd4);
      write_reg(REG_MAX_MISMATCHES, 3'd4);
      push_text(5);
      drain();
      // Length zero taken as one.
      write_reg(REG_KMER_LENGTH, 3'd0);
      write_reg(REG_MAX_MISMATCHES, 3'd0);
      push_text(6);
      drain();
      // Length above the maximum saturates; widest distance.
      write_reg(REG_KMER_LENGTH, 3'd7);
      write_reg(REG_MAX_MISMATCHES, 3'd6);
      push_text(7);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         write_reg(REG_KMER_LENGTH, 3'(ks[ph]));
         write_reg(REG_MAX_MISMATCHES, 3'(ds[ph]));
         set_mode(ph);
         maxlen = (ks[ph] >= 5) ? 9 : 30;
         sent = 0;
         while (sent < 38) begin
            len = $urandom_range(1, maxlen);
            if (len > 38 - sent) len = 38 - sent;
            push_text(len);
            sent += len;
         end
         drain();
      end

      $display("Covered %0d texts with out-of-range k, full ties and random k and d,",
               texts_sent);
      $display("under idle and stall phases; %0d results checked.", hits_checked);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(8 * 10_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/fkm_pkg.sv
hdl/frequent_kmer_with_mismatches_core.sv
test/tb.sv
